@@ design/mrc_pkg.sv @@
`timescale 1ns / 1ps

package mrc_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 256;

  // request function codes with a special meaning
  localparam logic [7:0] FC_COILS       = 8'd1;
  localparam logic [7:0] FC_DISCRETE    = 8'd2;
  localparam logic [7:0] FC_HOLDING     = 8'd3;
  localparam logic [7:0] FC_INPUT       = 8'd4;
  localparam logic [7:0] FC_EXC_STATUS  = 8'd7;
  localparam logic [7:0] FC_MULTI_COILS = 8'd15;
  localparam logic [7:0] FC_MULTI_REGS  = 8'd16;
  localparam logic [7:0] FC_SLAVE_ID    = 8'd17;
  localparam logic [7:0] FC_WRITE_READ  = 8'd23;

  // configuration register indexes
  localparam logic CFG_REQ_FUNCTION = 1'b0;
  localparam logic CFG_REQ_QUANTITY = 1'b1;

  localparam logic [7:0] REQ_FUNCTION_RST = FC_HOLDING;
  localparam logic [15:0] REQ_QUANTITY_RST = 16'd1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LENGTH    = 3'd1,
    ST_FUNCTION  = 3'd2,
    ST_COUNT     = 3'd3,
    ST_EXCEPTION = 3'd4
  } status_e;

  typedef struct packed {
    logic        is_verdict;
    logic [15:0] reg_value;
    status_e     status;
    logic [15:0] value_count;
  } result_t;

endpackage

@@ design/modbus_rtu_response_check.sv @@
`timescale 1ns / 1ps

// Modbus RTU response checker. Response bytes enter on the slave stream one item per
// cycle, slave address first, with tlast on the final byte; CRC is not checked.
// For register reads each data word is sent out provisionally (tuser low) as its
// byte pair completes; the tlast byte yields one verdict (tuser high) with a status
// and, when ok, the confirmed value count. A byte passes an input register and a
// result register before its result is offered, and one byte per cycle is sustained
// as long as results are taken. The user must write the request function code and
// quantity through the config port only while no frame is in flight; the block
// itself does not enforce this. No clearing pass after reset.

module modbus_rtu_response_check #(
  parameter int unsigned MAX_FRAME_BYTES = mrc_pkg::MAX_FRAME_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rsp_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // reg_value[15:0], status[18:16], value_count[34:19]
  output logic        m_axis_tuser,   // is_verdict
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [7:0]       req_function_q;
  logic [15:0]      req_quantity_q;

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             in_last;
  logic             out_free;
  logic             advance;
  logic             res_valid;
  mrc_pkg::result_t res;
  mrc_pkg::result_t out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_function_q <= mrc_pkg::REQ_FUNCTION_RST;
      req_quantity_q <= mrc_pkg::REQ_QUANTITY_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == mrc_pkg::CFG_REQ_FUNCTION) begin
        req_function_q <= cfg_data_i[7:0];
      end
      if (cfg_index_i == mrc_pkg::CFG_REQ_QUANTITY) begin
        req_quantity_q <= cfg_data_i;
      end
    end
  end

  assign advance = in_valid && out_free;

  mrc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .byte_i    (s_axis_tdata),
    .last_i    (s_axis_tlast),
    .advance_i (advance),
    .valid_o   (in_valid),
    .byte_o    (in_byte),
    .last_o    (in_last)
  );

  mrc_frame #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_frame (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .byte_i         (in_byte),
    .last_i         (in_last),
    .req_function_i (req_function_q),
    .req_quantity_i (req_quantity_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  mrc_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (res_valid),
    .res_i     (res),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (out_res)
  );

  assign m_axis_tdata = {5'd0, out_res.value_count, 3'(out_res.status), out_res.reg_value};
  assign m_axis_tuser = out_res.is_verdict;

  // a provisional word carries neither status nor count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[34:16] == 19'd0)
    else $error("provisional word with status or count");

  // an empty result register never blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // a verdict with a nonzero count must be ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && m_axis_tdata[34:19] != 16'd0
      |-> m_axis_tdata[18:16] == 3'(mrc_pkg::ST_OK))
    else $error("count reported on a failed verdict");

endmodule

@@ design/mrc_in_reg.sv @@
`timescale 1ns / 1ps

module mrc_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic       valid_d, valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       load;

  // slot frees up in the same cycle its item moves on
  assign s_ready_o = !valid_q || advance_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_i;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

@@ design/mrc_frame.sv @@
`timescale 1ns / 1ps

module mrc_frame #(
  parameter int unsigned MAX_FRAME_BYTES = mrc_pkg::MAX_FRAME_BYTES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  input  logic [7:0]       req_function_i,
  input  logic [15:0]      req_quantity_i,
  output logic             res_valid_o,
  output mrc_pkg::result_t res_o
);

  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [PosW-1:0] PosMax  = PosW'(MAX_FRAME_BYTES);
  localparam logic [PosW-1:0] PosOver = PosW'(MAX_FRAME_BYTES + 1);

  logic [PosW-1:0] pos_d, pos_q;
  logic [7:0]      func_d, func_q;
  logic [7:0]      cnt_d, cnt_q;
  logic [15:0]     word_d, word_q;
  logic [7:0]      pend_d, pend_q;

  logic            is_reg_read;
  logic            word_ready;
  logic [13:0]     ceil8;
  logic [17:0]     expect_len;
  logic            any_len;
  logic            cnt_ok;
  logic [15:0]     cnt_val;
  logic            len_ok;
  logic            exc_match;
  mrc_pkg::status_e status;
  logic [15:0]     count;

  assign is_reg_read = req_function_i inside {mrc_pkg::FC_HOLDING, mrc_pkg::FC_INPUT,
                                              mrc_pkg::FC_WRITE_READ};

  // field capture and byte position, before any clearing at the frame end
  always_comb begin
    func_d     = func_q;
    cnt_d      = cnt_q;
    word_d     = word_q;
    pend_d     = pend_q;
    pos_d      = PosOver;
    word_ready = 1'b0;
    if (pos_q < PosMax) begin
      pos_d = pos_q + PosW'(1);
      if (pos_q == PosW'(1)) begin
        func_d = byte_i;
      end
      if (pos_q == PosW'(2)) begin
        cnt_d = byte_i;
      end
      if (pos_q == PosW'(4) || pos_q == PosW'(5)) begin
        word_d = {word_q[7:0], byte_i};
      end
      if (pos_q >= PosW'(3) && pos_q[0]) begin
        pend_d = byte_i;
      end
      // low byte of a data word inside the announced byte count
      if (pos_q >= PosW'(4) && !pos_q[0] && (32'(pos_q) - 32'd2) <= 32'(cnt_q) &&
          is_reg_read && func_q == req_function_i) begin
        word_ready = 1'b1;
      end
    end
  end

  assign ceil8 = {1'b0, req_quantity_i[15:3]} + 14'(|req_quantity_i[2:0]);

  always_comb begin
    expect_len = 18'd8;
    any_len    = 1'b0;
    cnt_ok     = 1'b1;
    cnt_val    = 16'd1;
    case (req_function_i)
      mrc_pkg::FC_COILS, mrc_pkg::FC_DISCRETE: begin
        expect_len = 18'd5 + 18'(ceil8);
        cnt_ok     = ceil8 == 14'(cnt_d);
        cnt_val    = 16'(cnt_d);
      end
      mrc_pkg::FC_HOLDING, mrc_pkg::FC_INPUT, mrc_pkg::FC_WRITE_READ: begin
        expect_len = 18'd5 + 18'({req_quantity_i, 1'b0});
        cnt_ok     = req_quantity_i == 16'(cnt_d[7:1]);
        cnt_val    = 16'(cnt_d[7:1]);
      end
      mrc_pkg::FC_EXC_STATUS: begin
        expect_len = 18'd6;
      end
      mrc_pkg::FC_MULTI_COILS, mrc_pkg::FC_MULTI_REGS: begin
        cnt_ok  = req_quantity_i == word_d;
        cnt_val = word_d;
      end
      mrc_pkg::FC_SLAVE_ID: begin
        any_len = 1'b1;
        cnt_val = 16'(cnt_d);
      end
      default: begin
        expect_len = 18'd8;
      end
    endcase
  end

  assign len_ok    = any_len || (32'(pos_d) == 32'(expect_len));
  // exception reply carries the request code with the top bit set
  assign exc_match = (32'(pos_d) == 32'd5) && func_d[7] && !req_function_i[7] &&
                     (func_d[6:0] == req_function_i[6:0]);

  always_comb begin
    status = mrc_pkg::ST_LENGTH;
    count  = 16'd0;
    if (32'(pos_d) > MAX_FRAME_BYTES) begin
      status = mrc_pkg::ST_LENGTH;
    end else if (len_ok) begin
      if (func_d != req_function_i) begin
        status = mrc_pkg::ST_FUNCTION;
      end else if (cnt_ok) begin
        status = mrc_pkg::ST_OK;
        count  = cnt_val;
      end else begin
        status = mrc_pkg::ST_COUNT;
      end
    end else if (exc_match) begin
      status = mrc_pkg::ST_EXCEPTION;
    end
  end

  always_comb begin
    res_o = '0;
    if (last_i) begin
      res_o.is_verdict  = 1'b1;
      res_o.status      = status;
      res_o.value_count = count;
    end else begin
      res_o.reg_value = {pend_q, byte_i};
      res_o.status    = mrc_pkg::ST_OK;
    end
  end

  assign res_valid_o = step_i && (last_i || word_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      func_q <= '0;
      cnt_q  <= '0;
      word_q <= '0;
      pend_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        pos_q  <= '0;
        func_q <= '0;
        cnt_q  <= '0;
        word_q <= '0;
        pend_q <= '0;
      end else begin
        pos_q  <= pos_d;
        func_q <= func_d;
        cnt_q  <= cnt_d;
        word_q <= word_d;
        pend_q <= pend_d;
      end
    end
  end

endmodule

@@ design/mrc_out_reg.sv @@
`timescale 1ns / 1ps

module mrc_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  mrc_pkg::result_t res_i,
  output logic             free_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output mrc_pkg::result_t res_o
);

  logic             valid_d, valid_q;
  mrc_pkg::result_t res_q;

  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign res_o     = res_q;

endmodule
